// ===== hw/rtl/raid_stripe_address_map_defines.svh =====
// assertion macros shared by the checker
`ifndef RAID_STRIPE_ADDRESS_MAP_DEFINES_SVH
`define RAID_STRIPE_ADDRESS_MAP_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define RSAM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("raid_stripe_address_map check failed");

// next-cycle implication, disabled while rst is high
`define RSAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("raid_stripe_address_map check failed");

`endif

// ===== hw/rtl/rsam_pkg.sv =====
package rsam_pkg;

   localparam int CHUNK_SLOTS_DEF = 64;
   localparam int MAX_STRIPES_DEF = 16;
   localparam int RESULT_LIMIT    = 16;
   localparam int DIV_STEPS       = 64;

   localparam logic [1:0] OP_LOAD_CHUNK  = 2'd0;
   localparam logic [1:0] OP_LOAD_STRIPE = 2'd1;
   localparam logic [1:0] OP_MAP         = 2'd2;

   localparam logic [2:0] PROF_SINGLE  = 3'd0;
   localparam logic [2:0] PROF_RAID0   = 3'd1;
   localparam logic [2:0] PROF_RAID1   = 3'd2;
   localparam logic [2:0] PROF_DUP     = 3'd3;
   localparam logic [2:0] PROF_RAID10  = 3'd4;
   localparam logic [2:0] PROF_RAID5   = 3'd5;
   localparam logic [2:0] PROF_RAID6   = 3'd6;
   localparam logic [2:0] PROF_UNSUPP  = 3'd7;

   localparam logic [1:0] RSP_MAPPED    = 2'd0;
   localparam logic [1:0] RSP_LOADED    = 2'd1;
   localparam logic [1:0] RSP_NOT_FOUND = 2'd2;
   localparam logic [1:0] RSP_BAD       = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WR_CHUNK,
      ST_WR_STRIPE,
      ST_BAD_OP,
      ST_SRCH_INIT,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_GEOM,
      ST_DIV_OFF,
      ST_POST_OFF,
      ST_START_A,
      ST_DIV_A,
      ST_POST_A,
      ST_START_B,
      ST_DIV_B,
      ST_POST_B,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_BASE,
      ST_COPY_RD,
      ST_COPY_FORM,
      ST_PUSH
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_ACCEPT,
      DP_WR_CHUNK,
      DP_WR_STRIPE,
      DP_SET_BAD,
      DP_SET_NOT_FOUND,
      DP_SRCH_INIT,
      DP_SRCH_RD,
      DP_SRCH_CMP,
      DP_START_OFF,
      DP_DIV_STEP,
      DP_POST_OFF,
      DP_START_NS,
      DP_SET_MIRROR,
      DP_START_FACTOR,
      DP_START_DATA,
      DP_POST_R0,
      DP_POST_FACTOR,
      DP_POST_DATA,
      DP_START_SNRF,
      DP_START_MODNS,
      DP_POST_R10,
      DP_POST_PAR,
      DP_MUL_LO,
      DP_MUL_HI,
      DP_ADD_BASE,
      DP_COPY_RD,
      DP_COPY_FORM,
      DP_PUSH
   } dp_op_type;

   typedef enum logic [1:0] {
      CLS_STRIPE,
      CLS_MIRROR,
      CLS_R10,
      CLS_PARITY
   } cls_type;

   typedef struct packed {
      logic    srch_empty;
      logic    cmp_hit;
      logic    geom_bad;
      logic    div_done;
      cls_type cls;
      logic    out_free;
      logic    pend_last;
   } dp_stat_type;

endpackage

// ===== hw/rtl/rsam_ctrl.sv =====
module rsam_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_opcode,
   input  rsam_pkg::dp_stat_type dp_stat,
   output rsam_pkg::dp_op_type   dp_op,
   output logic                  req_stall
);

   rsam_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsam_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsam_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  rsam_pkg::OP_LOAD_CHUNK:  state_in = rsam_pkg::ST_WR_CHUNK;
                  rsam_pkg::OP_LOAD_STRIPE: state_in = rsam_pkg::ST_WR_STRIPE;
                  rsam_pkg::OP_MAP:         state_in = rsam_pkg::ST_SRCH_INIT;
                  default:                  state_in = rsam_pkg::ST_BAD_OP;
               endcase
            end
         end
         rsam_pkg::ST_WR_CHUNK:  state_in = rsam_pkg::ST_PUSH;
         rsam_pkg::ST_WR_STRIPE: state_in = rsam_pkg::ST_PUSH;
         rsam_pkg::ST_BAD_OP:    state_in = rsam_pkg::ST_PUSH;
         rsam_pkg::ST_SRCH_INIT: state_in = rsam_pkg::ST_SRCH_RD;
         rsam_pkg::ST_SRCH_RD: begin
            state_in = dp_stat.srch_empty ? rsam_pkg::ST_PUSH : rsam_pkg::ST_SRCH_CMP;
         end
         rsam_pkg::ST_SRCH_CMP: begin
            state_in = dp_stat.cmp_hit ? rsam_pkg::ST_GEOM : rsam_pkg::ST_SRCH_RD;
         end
         rsam_pkg::ST_GEOM: begin
            state_in = dp_stat.geom_bad ? rsam_pkg::ST_PUSH : rsam_pkg::ST_DIV_OFF;
         end
         rsam_pkg::ST_DIV_OFF: begin
            if (dp_stat.div_done) state_in = rsam_pkg::ST_POST_OFF;
         end
         rsam_pkg::ST_POST_OFF: state_in = rsam_pkg::ST_START_A;
         rsam_pkg::ST_START_A: begin
            state_in = (dp_stat.cls == rsam_pkg::CLS_MIRROR) ? rsam_pkg::ST_MUL_LO
                                                              : rsam_pkg::ST_DIV_A;
         end
         rsam_pkg::ST_DIV_A: begin
            if (dp_stat.div_done) state_in = rsam_pkg::ST_POST_A;
         end
         rsam_pkg::ST_POST_A: begin
            state_in = (dp_stat.cls == rsam_pkg::CLS_STRIPE) ? rsam_pkg::ST_MUL_LO
                                                              : rsam_pkg::ST_START_B;
         end
         rsam_pkg::ST_START_B: state_in = rsam_pkg::ST_DIV_B;
         rsam_pkg::ST_DIV_B: begin
            if (dp_stat.div_done) state_in = rsam_pkg::ST_POST_B;
         end
         rsam_pkg::ST_POST_B:    state_in = rsam_pkg::ST_MUL_LO;
         rsam_pkg::ST_MUL_LO:    state_in = rsam_pkg::ST_MUL_HI;
         rsam_pkg::ST_MUL_HI:    state_in = rsam_pkg::ST_BASE;
         rsam_pkg::ST_BASE:      state_in = rsam_pkg::ST_COPY_RD;
         rsam_pkg::ST_COPY_RD:   state_in = rsam_pkg::ST_COPY_FORM;
         rsam_pkg::ST_COPY_FORM: state_in = rsam_pkg::ST_PUSH;
         rsam_pkg::ST_PUSH: begin
            if (dp_stat.out_free) begin
               state_in = dp_stat.pend_last ? rsam_pkg::ST_IDLE : rsam_pkg::ST_COPY_RD;
            end
         end
         default: state_in = rsam_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      dp_op     = rsam_pkg::DP_NOP;
      req_stall = (state_ff != rsam_pkg::ST_IDLE);
      unique case (state_ff)
         rsam_pkg::ST_IDLE: begin
            if (req_valid) dp_op = rsam_pkg::DP_ACCEPT;
         end
         rsam_pkg::ST_WR_CHUNK:  dp_op = rsam_pkg::DP_WR_CHUNK;
         rsam_pkg::ST_WR_STRIPE: dp_op = rsam_pkg::DP_WR_STRIPE;
         rsam_pkg::ST_BAD_OP:    dp_op = rsam_pkg::DP_SET_BAD;
         rsam_pkg::ST_SRCH_INIT: dp_op = rsam_pkg::DP_SRCH_INIT;
         rsam_pkg::ST_SRCH_RD: begin
            dp_op = dp_stat.srch_empty ? rsam_pkg::DP_SET_NOT_FOUND : rsam_pkg::DP_SRCH_RD;
         end
         rsam_pkg::ST_SRCH_CMP: dp_op = rsam_pkg::DP_SRCH_CMP;
         rsam_pkg::ST_GEOM: begin
            dp_op = dp_stat.geom_bad ? rsam_pkg::DP_SET_BAD : rsam_pkg::DP_START_OFF;
         end
         rsam_pkg::ST_DIV_OFF, rsam_pkg::ST_DIV_A, rsam_pkg::ST_DIV_B: begin
            if (!dp_stat.div_done) dp_op = rsam_pkg::DP_DIV_STEP;
         end
         rsam_pkg::ST_POST_OFF: dp_op = rsam_pkg::DP_POST_OFF;
         rsam_pkg::ST_START_A: begin
            unique case (dp_stat.cls)
               rsam_pkg::CLS_STRIPE: dp_op = rsam_pkg::DP_START_NS;
               rsam_pkg::CLS_MIRROR: dp_op = rsam_pkg::DP_SET_MIRROR;
               rsam_pkg::CLS_R10:    dp_op = rsam_pkg::DP_START_FACTOR;
               rsam_pkg::CLS_PARITY: dp_op = rsam_pkg::DP_START_DATA;
               default:              dp_op = rsam_pkg::DP_NOP;
            endcase
         end
         rsam_pkg::ST_POST_A: begin
            unique case (dp_stat.cls)
               rsam_pkg::CLS_STRIPE: dp_op = rsam_pkg::DP_POST_R0;
               rsam_pkg::CLS_R10:    dp_op = rsam_pkg::DP_POST_FACTOR;
               rsam_pkg::CLS_PARITY: dp_op = rsam_pkg::DP_POST_DATA;
               default:              dp_op = rsam_pkg::DP_NOP;
            endcase
         end
         rsam_pkg::ST_START_B: begin
            unique case (dp_stat.cls)
               rsam_pkg::CLS_R10:    dp_op = rsam_pkg::DP_START_SNRF;
               rsam_pkg::CLS_PARITY: dp_op = rsam_pkg::DP_START_MODNS;
               default:              dp_op = rsam_pkg::DP_NOP;
            endcase
         end
         rsam_pkg::ST_POST_B: begin
            unique case (dp_stat.cls)
               rsam_pkg::CLS_R10:    dp_op = rsam_pkg::DP_POST_R10;
               rsam_pkg::CLS_PARITY: dp_op = rsam_pkg::DP_POST_PAR;
               default:              dp_op = rsam_pkg::DP_NOP;
            endcase
         end
         rsam_pkg::ST_MUL_LO:    dp_op = rsam_pkg::DP_MUL_LO;
         rsam_pkg::ST_MUL_HI:    dp_op = rsam_pkg::DP_MUL_HI;
         rsam_pkg::ST_BASE:      dp_op = rsam_pkg::DP_ADD_BASE;
         rsam_pkg::ST_COPY_RD:   dp_op = rsam_pkg::DP_COPY_RD;
         rsam_pkg::ST_COPY_FORM: dp_op = rsam_pkg::DP_COPY_FORM;
         rsam_pkg::ST_PUSH: begin
            if (dp_stat.out_free) dp_op = rsam_pkg::DP_PUSH;
         end
         default: dp_op = rsam_pkg::DP_NOP;
      endcase
   end

endmodule

// ===== hw/rtl/rsam_dp.sv =====
module rsam_dp #(
   parameter int CHUNK_SLOTS = rsam_pkg::CHUNK_SLOTS_DEF,
   parameter int MAX_STRIPES = rsam_pkg::MAX_STRIPES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsam_pkg::dp_op_type   dp_op,
   output rsam_pkg::dp_stat_type dp_stat,
   input  logic                  csr_write_enable,
   input  logic [6:0]            csr_write_data,
   input  logic [5:0]            req_chunk_slot,
   input  logic [3:0]            req_stripe_slot,
   input  logic [63:0]           req_chunk_start,
   input  logic [63:0]           req_chunk_length,
   input  logic [31:0]           req_stripe_length,
   input  logic [2:0]            req_profile,
   input  logic [4:0]            req_stripe_total,
   input  logic [4:0]            req_sub_stripe_total,
   input  logic [63:0]           req_device_id,
   input  logic [63:0]           req_device_offset,
   input  logic [63:0]           req_logical_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [63:0]           rsp_out_device_id,
   output logic [63:0]           rsp_physical_offset,
   output logic                  rsp_last
);

   localparam int CW    = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
   localparam int CNW   = $clog2(CHUNK_SLOTS + 1);
   localparam int SW    = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
   localparam int DEPTH = CHUNK_SLOTS * MAX_STRIPES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [63:0] start_mem [CHUNK_SLOTS];
   logic [63:0] len_mem   [CHUNK_SLOTS];
   logic [44:0] geom_mem  [CHUNK_SLOTS];
   logic [63:0] dev_mem   [DEPTH];
   logic [63:0] sst_mem   [DEPTH];

   logic [6:0]  count_ff;
   logic [5:0]  cslot_ff;
   logic [3:0]  sslot_ff;
   logic [63:0] cstart_ff, clen_ff, devid_ff, devoff_ff, addr_ff;
   logic [44:0] cgeom_ff;

   logic [CNW-1:0] lo_ff, hi_ff, mid_ff, mid, n_lim;
   logic [63:0]    rd_start_ff, rd_len_ff;
   logic [44:0]    rd_geom_ff;

   logic [63:0] div_q_ff;
   logic [31:0] div_r_ff, div_d_ff;
   logic [6:0]  div_cnt_ff;
   logic [32:0] div_sh, div_diff;
   logic        div_ge;

   logic [63:0] snr_ff, acc_ff, prod_ff, base_ff;
   logic [31:0] soff_ff;
   logic [4:0]  factor_ff, idx_ff, copies_ff, i_ff;
   logic [63:0] rd_dev_ff, rd_sst_ff;

   logic [1:0]  pend_status_ff;
   logic [63:0] pend_dev_ff, pend_off_ff;
   logic        pend_last_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [63:0] rsp_dev_ff, rsp_off_ff;
   logic        rsp_last_ff;

   logic [31:0] g_slen;
   logic [2:0]  g_prof;
   logic [4:0]  g_ns, g_sub;
   logic        below, above, wr_chunk_ok, wr_stripe_ok;
   logic [5:0]  s_sum;
   logic [SW-1:0] s_mod;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [CW-1:0] wr_slot;

   assign g_slen = rd_geom_ff[31:0];
   assign g_prof = rd_geom_ff[34:32];
   assign g_ns   = rd_geom_ff[39:35];
   assign g_sub  = rd_geom_ff[44:40];

   always_comb begin
      if (int'(count_ff) > CHUNK_SLOTS) begin
         n_lim = CNW'(CHUNK_SLOTS);
      end else begin
         n_lim = CNW'(count_ff);
      end
   end

   assign mid   = lo_ff + ((hi_ff - lo_ff - CNW'(1)) >> 1);
   assign below = addr_ff < rd_start_ff;
   assign above = !below && ((addr_ff - rd_start_ff) >= rd_len_ff);

   assign div_sh   = {div_r_ff, div_q_ff[63]};
   assign div_diff = div_sh - {1'b0, div_d_ff};
   assign div_ge   = div_sh >= {1'b0, div_d_ff};

   assign s_sum = {1'b0, idx_ff} + {1'b0, i_ff};
   always_comb begin
      if (int'(s_sum) >= MAX_STRIPES) begin
         s_mod = SW'(int'(s_sum) - MAX_STRIPES);
      end else begin
         s_mod = SW'(s_sum);
      end
   end

   assign rd_addr      = AW'(int'(mid_ff[CW-1:0]) * MAX_STRIPES + int'(s_mod));
   assign wr_addr      = AW'(int'(cslot_ff) * MAX_STRIPES + int'(sslot_ff));
   assign wr_slot      = CW'(cslot_ff);
   assign wr_chunk_ok  = int'(cslot_ff) < CHUNK_SLOTS;
   assign wr_stripe_ok = wr_chunk_ok && (int'(sslot_ff) < MAX_STRIPES);

   always_comb begin
      dp_stat.srch_empty = lo_ff >= hi_ff;
      dp_stat.cmp_hit    = !below && !above;
      dp_stat.geom_bad   = (g_prof == rsam_pkg::PROF_UNSUPP) || (g_slen == 32'd0)
                        || (g_ns == 5'd0) || (int'(g_ns) > MAX_STRIPES)
                        || (int'(g_ns) > rsam_pkg::RESULT_LIMIT)
                        || ((g_prof == rsam_pkg::PROF_RAID10)
                            && ((g_sub == 5'd0) || (g_sub > g_ns)))
                        || ((g_prof == rsam_pkg::PROF_RAID5) && (g_ns <= 5'd1))
                        || ((g_prof == rsam_pkg::PROF_RAID6) && (g_ns <= 5'd2));
      dp_stat.div_done   = div_cnt_ff == 7'd0;
      dp_stat.out_free   = !rsp_valid_ff || !rsp_stall;
      dp_stat.pend_last  = pend_last_ff;
      unique case (g_prof)
         rsam_pkg::PROF_SINGLE, rsam_pkg::PROF_RAID0: dp_stat.cls = rsam_pkg::CLS_STRIPE;
         rsam_pkg::PROF_RAID1, rsam_pkg::PROF_DUP:    dp_stat.cls = rsam_pkg::CLS_MIRROR;
         rsam_pkg::PROF_RAID10:                       dp_stat.cls = rsam_pkg::CLS_R10;
         default:                                     dp_stat.cls = rsam_pkg::CLS_PARITY;
      endcase
   end

   // table memories
   always_ff @(posedge clock) begin
      if (dp_op == rsam_pkg::DP_WR_CHUNK && wr_chunk_ok) begin
         start_mem[wr_slot] <= cstart_ff;
         len_mem[wr_slot]   <= clen_ff;
         geom_mem[wr_slot]  <= cgeom_ff;
      end
      if (dp_op == rsam_pkg::DP_SRCH_RD) begin
         rd_start_ff <= start_mem[mid[CW-1:0]];
         rd_len_ff   <= len_mem[mid[CW-1:0]];
         rd_geom_ff  <= geom_mem[mid[CW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_op == rsam_pkg::DP_WR_STRIPE && wr_stripe_ok) begin
         dev_mem[wr_addr] <= devid_ff;
         sst_mem[wr_addr] <= devoff_ff;
      end
      if (dp_op == rsam_pkg::DP_COPY_RD) begin
         rd_dev_ff <= dev_mem[rd_addr];
         rd_sst_ff <= sst_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= 7'd0;
      end else begin
         unique case (dp_op)
            rsam_pkg::DP_START_OFF, rsam_pkg::DP_START_NS, rsam_pkg::DP_START_FACTOR,
            rsam_pkg::DP_START_DATA, rsam_pkg::DP_START_SNRF, rsam_pkg::DP_START_MODNS:
               div_cnt_ff <= 7'(rsam_pkg::DIV_STEPS);
            rsam_pkg::DP_DIV_STEP: div_cnt_ff <= div_cnt_ff - 7'd1;
            default: div_cnt_ff <= div_cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (dp_op)
         rsam_pkg::DP_ACCEPT: begin
            cslot_ff  <= req_chunk_slot;
            sslot_ff  <= req_stripe_slot;
            cstart_ff <= req_chunk_start;
            clen_ff   <= req_chunk_length;
            cgeom_ff  <= {req_sub_stripe_total, req_stripe_total, req_profile,
                          req_stripe_length};
            devid_ff  <= req_device_id;
            devoff_ff <= req_device_offset;
            addr_ff   <= req_logical_address;
         end
         rsam_pkg::DP_WR_CHUNK, rsam_pkg::DP_WR_STRIPE: begin
            pend_status_ff <= rsam_pkg::RSP_LOADED;
            pend_dev_ff    <= 64'd0;
            pend_off_ff    <= 64'd0;
            pend_last_ff   <= 1'b1;
         end
         rsam_pkg::DP_SET_BAD: begin
            pend_status_ff <= rsam_pkg::RSP_BAD;
            pend_dev_ff    <= 64'd0;
            pend_off_ff    <= 64'd0;
            pend_last_ff   <= 1'b1;
         end
         rsam_pkg::DP_SET_NOT_FOUND: begin
            pend_status_ff <= rsam_pkg::RSP_NOT_FOUND;
            pend_dev_ff    <= 64'd0;
            pend_off_ff    <= 64'd0;
            pend_last_ff   <= 1'b1;
         end
         rsam_pkg::DP_SRCH_INIT: begin
            lo_ff <= '0;
            hi_ff <= n_lim;
         end
         rsam_pkg::DP_SRCH_RD: mid_ff <= mid;
         rsam_pkg::DP_SRCH_CMP: begin
            if (below) begin
               hi_ff <= mid_ff;
            end else if (above) begin
               lo_ff <= mid_ff + CNW'(1);
            end
         end
         rsam_pkg::DP_START_OFF: begin
            div_q_ff <= addr_ff - rd_start_ff;
            div_r_ff <= 32'd0;
            div_d_ff <= g_slen;
         end
         rsam_pkg::DP_DIV_STEP: begin
            div_q_ff <= {div_q_ff[62:0], div_ge};
            div_r_ff <= div_ge ? div_diff[31:0] : div_sh[31:0];
         end
         rsam_pkg::DP_POST_OFF: begin
            snr_ff  <= div_q_ff;
            soff_ff <= div_r_ff;
         end
         rsam_pkg::DP_START_NS: begin
            div_q_ff <= snr_ff;
            div_r_ff <= 32'd0;
            div_d_ff <= 32'(g_ns);
         end
         rsam_pkg::DP_SET_MIRROR: begin
            idx_ff    <= 5'd0;
            copies_ff <= g_ns;
         end
         rsam_pkg::DP_START_FACTOR: begin
            div_q_ff <= 64'(g_ns);
            div_r_ff <= 32'd0;
            div_d_ff <= 32'(g_sub);
         end
         rsam_pkg::DP_START_DATA: begin
            div_q_ff <= snr_ff;
            div_r_ff <= 32'd0;
            div_d_ff <= (g_prof == rsam_pkg::PROF_RAID6) ? 32'(g_ns - 5'd2)
                                                         : 32'(g_ns - 5'd1);
         end
         rsam_pkg::DP_POST_R0: begin
            snr_ff    <= div_q_ff;
            idx_ff    <= div_r_ff[4:0];
            copies_ff <= 5'd1;
         end
         rsam_pkg::DP_POST_FACTOR: factor_ff <= div_q_ff[4:0];
         rsam_pkg::DP_POST_DATA:   snr_ff <= div_q_ff;
         rsam_pkg::DP_START_SNRF: begin
            div_q_ff <= snr_ff;
            div_r_ff <= 32'd0;
            div_d_ff <= 32'(factor_ff);
         end
         rsam_pkg::DP_START_MODNS: begin
            div_q_ff <= div_q_ff + 64'(div_r_ff[4:0]);
            div_r_ff <= 32'd0;
            div_d_ff <= 32'(g_ns);
         end
         rsam_pkg::DP_POST_R10: begin
            snr_ff    <= div_q_ff;
            idx_ff    <= 5'(div_r_ff[4:0] * g_sub);
            copies_ff <= g_sub;
         end
         rsam_pkg::DP_POST_PAR: begin
            idx_ff    <= div_r_ff[4:0];
            copies_ff <= 5'd1;
         end
         rsam_pkg::DP_MUL_LO: prod_ff <= 64'(snr_ff[31:0] * g_slen);
         rsam_pkg::DP_MUL_HI: begin
            acc_ff  <= prod_ff;
            prod_ff <= 64'(snr_ff[63:32] * g_slen);
         end
         rsam_pkg::DP_ADD_BASE: begin
            base_ff <= acc_ff + {prod_ff[31:0], 32'd0} + 64'(soff_ff);
            i_ff    <= 5'd0;
         end
         rsam_pkg::DP_COPY_FORM: begin
            pend_status_ff <= rsam_pkg::RSP_MAPPED;
            pend_dev_ff    <= rd_dev_ff;
            pend_off_ff    <= rd_sst_ff + base_ff;
            pend_last_ff   <= (i_ff + 5'd1) == copies_ff;
            i_ff           <= i_ff + 5'd1;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_op == rsam_pkg::DP_PUSH) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_op == rsam_pkg::DP_PUSH) begin
         rsp_status_ff <= pend_status_ff;
         rsp_dev_ff    <= pend_dev_ff;
         rsp_off_ff    <= pend_off_ff;
         rsp_last_ff   <= pend_last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_out_device_id   = rsp_dev_ff;
   assign rsp_physical_offset = rsp_off_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ===== hw/rtl/raid_stripe_address_map.sv =====
// Maps logical addresses to device locations through a loaded chunk table.
// Input channel req_*: one item per handshake, opcode selects load chunk
// header, load stripe entry or map address. The block takes one item at a
// time and holds req_stall high until the item's last result is in the
// output register.
// Result channel rsp_*: loads and rejects give one result; a map gives one
// result per stripe copy, rsp_last marks the final one.
// Steps: a load writes its table entry and then presents its result. A map
// runs a binary search of the chunk table, then serial divides on the
// shared radix-2 divider (1 for mirrors, 2 for single/raid0, 3 for
// raid10/raid5/raid6), a multiply and add, and a stripe memory read per copy.
// csr_write_data sets the searched entry count; it is to be written only
// while idle, which the user must ensure: the block does not enforce it.
// Reset clears the count, the controller and the output register; the
// table memories stay unknown until loaded.
// While rsp_stall is high the output register holds its item and the
// controller waits before presenting the next copy.
module raid_stripe_address_map #(
   parameter int CHUNK_SLOTS = rsam_pkg::CHUNK_SLOTS_DEF,
   parameter int MAX_STRIPES = rsam_pkg::MAX_STRIPES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_chunk_slot,
   input  logic [3:0]  req_stripe_slot,
   input  logic [63:0] req_chunk_start,
   input  logic [63:0] req_chunk_length,
   input  logic [31:0] req_stripe_length,
   input  logic [2:0]  req_profile,
   input  logic [4:0]  req_stripe_total,
   input  logic [4:0]  req_sub_stripe_total,
   input  logic [63:0] req_device_id,
   input  logic [63:0] req_device_offset,
   input  logic [63:0] req_logical_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_out_device_id,
   output logic [63:0] rsp_physical_offset,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data
);

   rsam_pkg::dp_op_type   dp_op;
   rsam_pkg::dp_stat_type dp_stat;

   rsam_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .dp_stat    (dp_stat),
      .dp_op      (dp_op),
      .req_stall  (req_stall)
   );

   rsam_dp #(
      .CHUNK_SLOTS (CHUNK_SLOTS),
      .MAX_STRIPES (MAX_STRIPES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .dp_op                (dp_op),
      .dp_stat              (dp_stat),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_chunk_slot       (req_chunk_slot),
      .req_stripe_slot      (req_stripe_slot),
      .req_chunk_start      (req_chunk_start),
      .req_chunk_length     (req_chunk_length),
      .req_stripe_length    (req_stripe_length),
      .req_profile          (req_profile),
      .req_stripe_total     (req_stripe_total),
      .req_sub_stripe_total (req_sub_stripe_total),
      .req_device_id        (req_device_id),
      .req_device_offset    (req_device_offset),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_out_device_id    (rsp_out_device_id),
      .rsp_physical_offset  (rsp_physical_offset),
      .rsp_last             (rsp_last)
   );

endmodule

// ===== hw/rtl/rsam_chk.sv =====
`include "raid_stripe_address_map_defines.svh"

module rsam_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_out_device_id,
   input logic [63:0] rsp_physical_offset,
   input logic        rsp_last
);

   // one item in flight: the block is busy right after taking one
   `RSAM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // anything but a mapping is a single zeroed result
   `RSAM_ASSERT_NOW(a_status_only, clock, reset, rsp_valid && (rsp_status != rsam_pkg::RSP_MAPPED), rsp_last && (rsp_out_device_id == 64'd0) && (rsp_physical_offset == 64'd0))

   // nothing is offered right after reset
   `RSAM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // a stalled result stays put
   `RSAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_physical_offset) && $stable(rsp_last))

endmodule

bind raid_stripe_address_map rsam_chk u_rsam_chk (.*);

// ===== test/raid_stripe_address_map_tb.sv =====
`timescale 1ns / 1ps
module raid_stripe_address_map_tb;

   localparam int SLOTS = 64;
   localparam int STRIPES = 16;
   localparam int DIRECTED = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef struct {
      bit [1:0]  opcode;
      bit [5:0]  chunk_slot;
      bit [3:0]  stripe_slot;
      bit [63:0] chunk_start;
      bit [63:0] chunk_length;
      bit [31:0] stripe_length;
      bit [2:0]  profile;
      bit [4:0]  stripe_total;
      bit [4:0]  sub_stripe_total;
      bit [63:0] device_id;
      bit [63:0] device_offset;
      bit [63:0] logical_address;
   } map_request_type;

   typedef struct {
      bit [1:0]  status;
      bit [63:0] device_id;
      bit [63:0] offset;
      bit        last;
   } copy_location_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_opcode = 0;
   logic [5:0]  req_chunk_slot = 0;
   logic [3:0]  req_stripe_slot = 0;
   logic [63:0] req_chunk_start = 0;
   logic [63:0] req_chunk_length = 0;
   logic [31:0] req_stripe_length = 0;
   logic [2:0]  req_profile = 0;
   logic [4:0]  req_stripe_total = 0;
   logic [4:0]  req_sub_stripe_total = 0;
   logic [63:0] req_device_id = 0;
   logic [63:0] req_device_offset = 0;
   logic [63:0] req_logical_address = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_out_device_id;
   logic [63:0] rsp_physical_offset;
   logic        rsp_last;
   logic        csr_write_enable = 0;
   logic [6:0]  csr_write_data = 0;

   // shadow copy of the chunk table
   bit [63:0] tbl_start [SLOTS];
   bit [63:0] tbl_len [SLOTS];
   bit [31:0] tbl_slen [SLOTS];
   bit [2:0]  tbl_prof [SLOTS];
   bit [4:0]  tbl_ns [SLOTS];
   bit [4:0]  tbl_sub [SLOTS];
   bit [63:0] tbl_dev [SLOTS][STRIPES];
   bit [63:0] tbl_base [SLOTS][STRIPES];
   bit [6:0]  searched_count = 0;

   copy_location_type expected_copies[$];
   copy_location_type head_copy;
   int mismatches = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit idle_on = 1;

   raid_stripe_address_map uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_chunk_slot(req_chunk_slot),
      .req_stripe_slot(req_stripe_slot), .req_chunk_start(req_chunk_start),
      .req_chunk_length(req_chunk_length), .req_stripe_length(req_stripe_length),
      .req_profile(req_profile), .req_stripe_total(req_stripe_total),
      .req_sub_stripe_total(req_sub_stripe_total), .req_device_id(req_device_id),
      .req_device_offset(req_device_offset), .req_logical_address(req_logical_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_device_id(rsp_out_device_id), .rsp_physical_offset(rsp_physical_offset),
      .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic map_request_type random_request();
      map_request_type it;
      it.opcode = 2'($urandom);
      it.chunk_slot = 6'($urandom);
      it.stripe_slot = 4'($urandom);
      it.chunk_start = rand64();
      it.chunk_length = rand64();
      it.stripe_length = $urandom;
      it.profile = 3'($urandom);
      it.stripe_total = 5'($urandom);
      it.sub_stripe_total = 5'($urandom);
      it.device_id = rand64();
      it.device_offset = rand64();
      it.logical_address = rand64();
      return it;
   endfunction

   // stripes that a map through this geometry can read
   function automatic int stripes_needed(bit [31:0] slen, bit [2:0] prof, bit [4:0] ns,
                                         bit [4:0] sub);
      if (prof == rsam_pkg::PROF_UNSUPP || slen == 32'd0 || ns == 5'd0 || int'(ns) > STRIPES)
         return 0;
      if (prof == rsam_pkg::PROF_RAID10 && (sub == 5'd0 || sub > ns)) return 0;
      if (prof == rsam_pkg::PROF_RAID5 && ns < 5'd2) return 0;
      if (prof == rsam_pkg::PROF_RAID6 && ns < 5'd3) return 0;
      return int'(ns);
   endfunction

   task automatic push_status(bit [1:0] st);
      copy_location_type r;
      r.status = st;
      r.device_id = '0;
      r.offset = '0;
      r.last = 1'b1;
      expected_copies.push_back(r);
   endtask

   task automatic predict_copies(map_request_type it);
      int lo, hi, mid, hit, n, k;
      bit [63:0] addr, off, snr, soff, idx, copies, factor, parity, data_cnt, slen, ns, sub, i;
      copy_location_type r;
      case (it.opcode)
         rsam_pkg::OP_LOAD_CHUNK: begin
            tbl_start[it.chunk_slot] = it.chunk_start;
            tbl_len[it.chunk_slot] = it.chunk_length;
            tbl_slen[it.chunk_slot] = it.stripe_length;
            tbl_prof[it.chunk_slot] = it.profile;
            tbl_ns[it.chunk_slot] = it.stripe_total;
            tbl_sub[it.chunk_slot] = it.sub_stripe_total;
            push_status(rsam_pkg::RSP_LOADED);
         end
         rsam_pkg::OP_LOAD_STRIPE: begin
            tbl_dev[it.chunk_slot][it.stripe_slot] = it.device_id;
            tbl_base[it.chunk_slot][it.stripe_slot] = it.device_offset;
            push_status(rsam_pkg::RSP_LOADED);
         end
         rsam_pkg::OP_MAP: begin
            addr = it.logical_address;
            n = int'(searched_count) > SLOTS ? SLOTS : int'(searched_count);
            lo = 0;
            hi = n - 1;
            hit = -1;
            while (lo <= hi && hit < 0) begin
               mid = lo + (hi - lo) / 2;
               if (addr < tbl_start[mid]) hi = mid - 1;
               else if (addr - tbl_start[mid] >= tbl_len[mid]) lo = mid + 1;
               else hit = mid;
            end
            if (hit < 0) begin
               push_status(rsam_pkg::RSP_NOT_FOUND);
               return;
            end
            slen = 64'(tbl_slen[hit]);
            ns = 64'(tbl_ns[hit]);
            sub = 64'(tbl_sub[hit]);
            if (tbl_prof[hit] == rsam_pkg::PROF_UNSUPP || slen == 64'd0 || ns == 64'd0
                || ns > 64'(STRIPES)) begin
               push_status(rsam_pkg::RSP_BAD);
               return;
            end
            off = addr - tbl_start[hit];
            snr = off / slen;
            soff = off - snr * slen;
            case (tbl_prof[hit])
               rsam_pkg::PROF_SINGLE, rsam_pkg::PROF_RAID0: begin
                  idx = snr % ns;
                  snr = snr / ns;
                  copies = 64'd1;
               end
               rsam_pkg::PROF_RAID1, rsam_pkg::PROF_DUP: begin
                  idx = 64'd0;
                  copies = ns;
               end
               rsam_pkg::PROF_RAID10: begin
                  if (sub == 64'd0 || sub > ns) begin
                     push_status(rsam_pkg::RSP_BAD);
                     return;
                  end
                  factor = ns / sub;
                  idx = (snr % factor) * sub;
                  snr = snr / factor;
                  copies = sub;
               end
               default: begin
                  parity = (tbl_prof[hit] == rsam_pkg::PROF_RAID6) ? 64'd2 : 64'd1;
                  if (ns <= parity) begin
                     push_status(rsam_pkg::RSP_BAD);
                     return;
                  end
                  data_cnt = ns - parity;
                  idx = snr % data_cnt;
                  snr = snr / data_cnt;
                  idx = (snr + idx) % ns;
                  copies = 64'd1;
               end
            endcase
            for (i = 64'd0; i < copies; i++) begin
               k = int'((idx + i) % 64'(STRIPES));
               r.status = rsam_pkg::RSP_MAPPED;
               r.device_id = tbl_dev[hit][k];
               r.offset = tbl_base[hit][k] + snr * slen + soff;
               r.last = (i + 64'd1 == copies);
               expected_copies.push_back(r);
            end
         end
         default: push_status(rsam_pkg::RSP_BAD);
      endcase
   endtask

   task automatic send_item(map_request_type it);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= it.opcode;
      req_chunk_slot <= it.chunk_slot;
      req_stripe_slot <= it.stripe_slot;
      req_chunk_start <= it.chunk_start;
      req_chunk_length <= it.chunk_length;
      req_stripe_length <= it.stripe_length;
      req_profile <= it.profile;
      req_stripe_total <= it.stripe_total;
      req_sub_stripe_total <= it.sub_stripe_total;
      req_device_id <= it.device_id;
      req_device_offset <= it.device_offset;
      req_logical_address <= it.logical_address;
      do @(posedge clock); while (req_stall);
      predict_copies(it);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_copies.size() != 0) @(posedge clock);
   endtask

   task automatic set_count(bit [6:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      searched_count = value;
   endtask

   task automatic load_chunk(int slot, bit [63:0] start, bit [63:0] len, bit [31:0] slen,
                             bit [2:0] prof, bit [4:0] ns, bit [4:0] sub, bit wrap_high);
      map_request_type it;
      it = random_request();
      it.opcode = rsam_pkg::OP_LOAD_CHUNK;
      it.chunk_slot = 6'(slot);
      it.chunk_start = start;
      it.chunk_length = len;
      it.stripe_length = slen;
      it.profile = prof;
      it.stripe_total = ns;
      it.sub_stripe_total = sub;
      send_item(it);
      // every stripe a valid geometry can touch gets written
      for (int k = 0; k < stripes_needed(slen, prof, ns, sub); k++) begin
         it = random_request();
         it.opcode = rsam_pkg::OP_LOAD_STRIPE;
         it.chunk_slot = 6'(slot);
         it.stripe_slot = 4'(k);
         if (wrap_high)
            it.device_offset = 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(0, 4095));
         send_item(it);
      end
   endtask

   task automatic pick_geometry(output bit [31:0] slen, output bit [2:0] prof,
                                output bit [4:0] ns, output bit [4:0] sub);
      prof = 3'($urandom_range(0, 6));
      ns = 5'($urandom_range(prof == rsam_pkg::PROF_RAID6 ? 3 :
                             prof == rsam_pkg::PROF_RAID5 ? 2 : 1, 16));
      sub = prof == rsam_pkg::PROF_RAID10 ? 5'($urandom_range(1, ns)) :
                                            5'($urandom_range(0, 31));
      case ($urandom_range(0, 3))
         0: slen = 32'd1 << $urandom_range(9, 20);
         1: slen = $urandom;
         2: slen = 32'hFFFF_FFFF;
         default: slen = 32'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 11))
         0: prof = rsam_pkg::PROF_UNSUPP;
         1: slen = 32'd0;
         2: ns = 5'd0;
         3: ns = 5'($urandom_range(17, 31));
         4: begin
            prof = rsam_pkg::PROF_RAID10;
            sub = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(ns + 1, 31));
         end
         5: begin
            prof = $urandom_range(0, 1) ? rsam_pkg::PROF_RAID5 : rsam_pkg::PROF_RAID6;
            ns = prof == rsam_pkg::PROF_RAID5 ? 5'd1 : 5'($urandom_range(1, 2));
         end
         default: ;
      endcase
   endtask

   function automatic bit [63:0] pick_address();
      int n, c;
      bit [63:0] len;
      n = int'(searched_count) > SLOTS ? SLOTS : int'(searched_count);
      if (n == 0) return rand64();
      if (n > DIRECTED && $urandom_range(0, 2) != 0) c = int'($urandom_range(0, DIRECTED - 1));
      else c = int'($urandom_range(0, n - 1));
      len = tbl_len[c];
      case ($urandom_range(0, 9))
         0: return rand64();
         1: return tbl_start[0] == 64'd0 ? 64'd0
                                         : tbl_start[0] - 64'd1 - rand64() % tbl_start[0];
         2: return $urandom_range(0, 1) ? 64'd0 : '1;
         3: return tbl_start[c] + (len == 64'd0 ? 64'd0 : len - 64'd1);
         4: return tbl_start[c] + len;
         default: return tbl_start[c] + (len == 64'd0 ? 64'd0 : rand64() % len);
      endcase
   endfunction

   task automatic run_maps(int count);
      map_request_type it;
      for (int i = 0; i < count; i++) begin
         it = random_request();
         case ($urandom_range(0, 15))
            0: it.opcode = OP_RESERVED;
            1: begin
               // rewrite a stripe entry in place
               it.opcode = rsam_pkg::OP_LOAD_STRIPE;
               it.chunk_slot = 6'($urandom_range(0, SLOTS - 1));
            end
            default: begin
               it.opcode = rsam_pkg::OP_MAP;
               it.logical_address = pick_address();
            end
         endcase
         send_item(it);
      end
   endtask

   task automatic send_map(bit [63:0] addr);
      map_request_type it;
      it = random_request();
      it.opcode = rsam_pkg::OP_MAP;
      it.logical_address = addr;
      send_item(it);
   endtask

   task automatic test_reset_defaults();
      map_request_type it;
      send_map(rand64());
      send_map('1);
      it = random_request();
      it.opcode = OP_RESERVED;
      send_item(it);
   endtask

   // directed profiles in the low slots, sparse chunks above up to the top address
   task automatic test_full_table();
      bit [2:0]  prof_l[DIRECTED] = '{
         rsam_pkg::PROF_SINGLE, rsam_pkg::PROF_RAID0, rsam_pkg::PROF_RAID1,
         rsam_pkg::PROF_DUP, rsam_pkg::PROF_RAID10, rsam_pkg::PROF_RAID5,
         rsam_pkg::PROF_RAID6, rsam_pkg::PROF_UNSUPP, rsam_pkg::PROF_RAID0,
         rsam_pkg::PROF_RAID1, rsam_pkg::PROF_RAID0, rsam_pkg::PROF_RAID10,
         rsam_pkg::PROF_RAID10, rsam_pkg::PROF_RAID5, rsam_pkg::PROF_RAID6,
         rsam_pkg::PROF_RAID1};
      bit [4:0]  ns_l[DIRECTED] = '{1, 3, 2, 2, 6, 3, 3, 4, 2, 0, 31, 4, 4, 1, 2, 8};
      bit [4:0]  sub_l[DIRECTED] = '{31, 0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0, 5, 0, 0, 0};
      bit [31:0] slen_l[DIRECTED] = '{4096, 65536, 512, 1, 4096, 4096, 32'hFFFF_FFFF, 4096,
                                     0, 4096, 4096, 4096, 4096, 4096, 4096, 4096};
      bit [63:0] base, stride, len, cursor, clen;
      bit [31:0] slen;
      bit [2:0]  prof;
      bit [4:0]  ns, sub;
      base = 64'h1000_0000;
      stride = 64'h0100_1000;
      len = 64'h0100_0000;
      for (int s = 0; s < DIRECTED; s++)
         load_chunk(s, base + 64'(s) * stride, len, slen_l[s], prof_l[s], ns_l[s], sub_l[s],
                    s == DIRECTED - 1);
      cursor = base + 64'(DIRECTED) * stride;
      for (int s = DIRECTED; s < SLOTS; s++) begin
         if ($urandom_range(0, 15) == 0) clen = 64'd0;
         else clen = (rand64() >> $urandom_range(28, 40)) + 64'd1;
         if (s == SLOTS - 1) clen = '1;
         pick_geometry(slen, prof, ns, sub);
         if (s != SLOTS / 2 && s != SLOTS - 1) prof = rsam_pkg::PROF_UNSUPP;
         load_chunk(s, cursor, clen, slen, prof, ns, sub, s == SLOTS - 1);
         cursor += clen;
         if ($urandom_range(0, 2) != 0) cursor += rand64() >> $urandom_range(24, 40);
      end
      set_count(7'(DIRECTED));
      for (int s = 0; s < DIRECTED; s++)
         send_map(base + 64'(s) * stride + (s == 0 ? 64'd0 : s == 6 ? len - 64'd1 :
                                            64'(s) * 64'd12345 + 64'd7));
      send_map(base - 64'd1);
      send_map(base + 64'(DIRECTED - 1) * stride + len);
      send_map(64'd0);
      send_map('1);
      set_count(7'd64);
      send_map('1);
      run_maps(6);
      set_count(7'd127);
      run_maps(4);
      set_count(7'd3);
      run_maps(2);
      set_count(7'd0);
      run_maps(2);
   endtask

   task automatic test_pressure();
      set_count(7'd64);
      for (int i = 0; i < 3; i++) begin
         send_map(pick_address());
         wait_drained();
      end
   endtask

   task automatic test_no_idle();
      wait_drained();
      idle_on = 0;
      run_maps(8);
   endtask

   always @(posedge clock) begin
      if (reset || !idle_on) begin
         stall_left <= 0;
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= int'($urandom_range(0, 10));
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_copies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: status=%0d dev=%h off=%h last=%0d",
                        rsp_status, rsp_out_device_id, rsp_physical_offset, rsp_last);
         end else begin
            head_copy = expected_copies.pop_front();
            if (rsp_status !== head_copy.status || rsp_out_device_id !== head_copy.device_id ||
                rsp_physical_offset !== head_copy.offset || rsp_last !== head_copy.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected status=%0d dev=%h off=%h last=%0d,",
                            " got status=%0d dev=%h off=%h last=%0d"},
                           head_copy.status, head_copy.device_id, head_copy.offset,
                           head_copy.last, rsp_status, rsp_out_device_id,
                           rsp_physical_offset, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_defaults();
      test_full_table();
      test_pressure();
      test_no_idle();
      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rsam_pkg.sv
hw/rtl/rsam_ctrl.sv
hw/rtl/rsam_dp.sv
hw/rtl/raid_stripe_address_map.sv
hw/rtl/rsam_chk.sv
test/raid_stripe_address_map_tb.sv
